// File: rtl/core/psgrlt_pkg.sv
// ----------------------------------------------------------------------------
// psgrlt_pkg
// shared constants and the note period table for the run-length note tracker
// ----------------------------------------------------------------------------
package psgrlt_pkg;

  localparam int unsigned NUM_CHANNELS  = 4;
  localparam int unsigned RUN_BITS      = 16;
  localparam int unsigned NOISE_CHANNEL = NUM_CHANNELS - 1;

  localparam int unsigned CHANNEL_W = 2;
  localparam int unsigned PERIOD_W  = 12;
  localparam int unsigned ATTEN_W   = 4;
  localparam int unsigned NOTE_W    = 12;
  localparam int unsigned RUN_LEN_W = 16;

  localparam int unsigned TABLE_SIZE = 96;
  localparam int unsigned MAX_NOTE   = TABLE_SIZE - 2;

  localparam logic [RUN_BITS-1:0] RUN_MAX = '1;

  localparam logic [PERIOD_W-1:0] PERIOD_TABLE [TABLE_SIZE] = '{
    12'h6ae, 12'h64e, 12'h5f4, 12'h59e, 12'h54e, 12'h502, 12'h4ba, 12'h476,
    12'h436, 12'h3f8, 12'h3c0, 12'h38a, 12'h357, 12'h327, 12'h2fa, 12'h2cf,
    12'h2a7, 12'h281, 12'h25d, 12'h23b, 12'h21b, 12'h1fc, 12'h1e0, 12'h1c5,
    12'h1ac, 12'h194, 12'h17d, 12'h168, 12'h153, 12'h140, 12'h12e, 12'h11d,
    12'h10d, 12'h0fe, 12'h0f0, 12'h0e3, 12'h0d6, 12'h0ca, 12'h0be, 12'h0b4,
    12'h0aa, 12'h0a0, 12'h097, 12'h08f, 12'h087, 12'h07f, 12'h078, 12'h071,
    12'h06b, 12'h065, 12'h05f, 12'h05a, 12'h055, 12'h050, 12'h04c, 12'h047,
    12'h043, 12'h040, 12'h03c, 12'h039, 12'h035, 12'h032, 12'h030, 12'h02d,
    12'h02a, 12'h028, 12'h026, 12'h024, 12'h022, 12'h020, 12'h01e, 12'h01c,
    12'h01b, 12'h019, 12'h018, 12'h016, 12'h015, 12'h014, 12'h013, 12'h012,
    12'h011, 12'h010, 12'h00f, 12'h00e, 12'h00d, 12'h00d, 12'h00c, 12'h00b,
    12'h00b, 12'h00a, 12'h009, 12'h008, 12'h007, 12'h006, 12'h005, 12'h004
  };

endpackage

// File: rtl/core/psgrlt_if.sv
// ----------------------------------------------------------------------------
// psgrlt_in_if / psgrlt_out_if
// valid/ready channels for sample beats and result beats
// ----------------------------------------------------------------------------
interface psgrlt_in_if
  import psgrlt_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CHANNEL_W-1:0] channel;
  logic [PERIOD_W-1:0]  period;
  logic [ATTEN_W-1:0]   attenuation;

  modport source (output valid, output channel, output period, output attenuation,
                  input ready);
  modport sink   (input valid, input channel, input period, input attenuation,
                  output ready);
endinterface

interface psgrlt_out_if
  import psgrlt_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CHANNEL_W-1:0] out_channel;
  logic                 new_run;
  logic [NOTE_W-1:0]    note_index;
  logic [ATTEN_W-1:0]   run_attenuation;
  logic [RUN_LEN_W-1:0] run_length;

  modport source (output valid, output out_channel, output new_run, output note_index,
                  output run_attenuation, output run_length, input ready);
  modport sink   (input valid, input out_channel, input new_run, input note_index,
                  input run_attenuation, input run_length, output ready);
endinterface

// File: rtl/core/psg_channel_run_length_note_tracker.sv
// ----------------------------------------------------------------------------
// psg_channel_run_length_note_tracker
// a sample beat is held in the input register, then its result in the result register
// throughput: one beat per cycle, sustained with no bubbles while the result is not stalled
// the input register and the result register decouple the two handshakes
// ready drops only while both registers hold a beat and the result is stalled
// reset (async, active low) empties both registers and clears every channel run
// ----------------------------------------------------------------------------
module psg_channel_run_length_note_tracker
  import psgrlt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  psgrlt_in_if.sink    in_i,
  psgrlt_out_if.source out_o
);

  logic                 in_valid_q;
  logic [CHANNEL_W-1:0] ch_q;
  logic [PERIOD_W-1:0]  per_q;
  logic [ATTEN_W-1:0]   att_q;

  logic                 run_valid_q   [NUM_CHANNELS];
  logic [PERIOD_W-1:0]  last_period_q [NUM_CHANNELS];
  logic [ATTEN_W-1:0]   last_att_q    [NUM_CHANNELS];
  logic [NOTE_W-1:0]    last_note_q   [NUM_CHANNELS];
  logic [RUN_BITS-1:0]  run_count_q   [NUM_CHANNELS];

  logic                 out_valid_q;
  logic [CHANNEL_W-1:0] out_ch_q;
  logic                 new_run_q, new_run_d;
  logic [NOTE_W-1:0]    note_q, note_d;
  logic [ATTEN_W-1:0]   run_att_q, run_att_d;
  logic [RUN_LEN_W-1:0] run_len_q, run_len_d;

  logic                 out_adv;
  logic                 take;
  logic                 in_range;
  logic                 is_tone;
  logic                 cur_valid;
  logic [PERIOD_W-1:0]  cur_period;
  logic [ATTEN_W-1:0]   cur_att;
  logic [NOTE_W-1:0]    cur_note;
  logic [RUN_BITS-1:0]  cur_count;
  logic                 fresh;
  logic [TABLE_SIZE-1:0] ge;
  logic [NOTE_W-1:0]    note_lut;
  logic [NOTE_W-1:0]    new_note;
  logic [RUN_BITS-1:0]  cnt_d;
  logic [31:0]          run_ext;

  // handshake
  assign out_adv    = !out_valid_q || out_o.ready;
  assign take       = in_valid_q && out_adv;
  assign in_i.ready = !in_valid_q || out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ch_q  <= in_i.channel;
      per_q <= in_i.period;
      att_q <= in_i.attenuation;
    end
  end

  // channel state read
  always_comb begin
    cur_valid  = 1'b0;
    cur_period = '0;
    cur_att    = '0;
    cur_note   = '0;
    cur_count  = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (int'(ch_q) == c) begin
        cur_valid  = run_valid_q[c];
        cur_period = last_period_q[c];
        cur_att    = last_att_q[c];
        cur_note   = last_note_q[c];
        cur_count  = run_count_q[c];
      end
    end
  end

  assign in_range = int'(ch_q) < NUM_CHANNELS;
  assign is_tone  = int'(ch_q) < NOISE_CHANNEL;
  assign fresh    = !cur_valid || (cur_period != per_q) || (cur_att != att_q);

  // parallel table compare, one-hot interval select
  always_comb begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      ge[i] = per_q >= PERIOD_TABLE[i];
    end
    note_lut = '0;
    for (int i = 0; i < TABLE_SIZE - 1; i++) begin
      if (ge[i+1] && !ge[i]) begin
        note_lut = note_lut | NOTE_W'(i);
      end
    end
  end

  assign new_note = (is_tone && (per_q != '0)) ? note_lut : per_q;

  always_comb begin
    if (fresh) begin
      cnt_d = RUN_BITS'(1);
    end else if (cur_count != RUN_MAX) begin
      cnt_d = cur_count + RUN_BITS'(1);
    end else begin
      cnt_d = cur_count;
    end
  end

  assign run_ext = 32'(cnt_d);

  always_comb begin
    if (in_range) begin
      new_run_d = fresh;
      note_d    = fresh ? new_note : cur_note;
      run_att_d = att_q;
      run_len_d = run_ext[RUN_LEN_W-1:0];
    end else begin
      new_run_d = 1'b0;
      note_d    = '0;
      run_att_d = att_q;
      run_len_d = '0;
    end
  end

  // channel state write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        run_valid_q[c]   <= 1'b0;
        last_period_q[c] <= '0;
        last_att_q[c]    <= '0;
        last_note_q[c]   <= '0;
        run_count_q[c]   <= '0;
      end
    end else if (take && in_range) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (int'(ch_q) == c) begin
          run_valid_q[c] <= 1'b1;
          run_count_q[c] <= cnt_d;
          if (fresh) begin
            last_period_q[c] <= per_q;
            last_att_q[c]    <= att_q;
            last_note_q[c]   <= new_note;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_ch_q  <= ch_q;
      new_run_q <= new_run_d;
      note_q    <= note_d;
      run_att_q <= run_att_d;
      run_len_q <= run_len_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.out_channel     = out_ch_q;
  assign out_o.new_run         = new_run_q;
  assign out_o.note_index      = note_q;
  assign out_o.run_attenuation = run_att_q;
  assign out_o.run_length      = run_len_q;

endmodule

// File: rtl/core/psgrlt_checker.sv
// ----------------------------------------------------------------------------
// psgrlt_checker
// port-level checks on the run-length note tracker, bound to the top level
// ----------------------------------------------------------------------------
module psgrlt_checker
  import psgrlt_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [CHANNEL_W-1:0] out_channel_i,
  input logic                 new_run_i,
  input logic [NOTE_W-1:0]    note_index_i,
  input logic [ATTEN_W-1:0]   run_attenuation_i,
  input logic [RUN_LEN_W-1:0] run_length_i
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_channel_i)
      && $stable(new_run_i) && $stable(note_index_i)
      && $stable(run_attenuation_i) && $stable(run_length_i))
    else $error("stalled result beat changed");

  // backpressure only from a stalled result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a stalled result");

  // a new run always reports length one
  a_new_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && new_run_i |-> run_length_i == RUN_LEN_W'(1))
    else $error("new run with length other than one");

  // tone notes stay inside the table range
  a_tone_note: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && new_run_i && (int'(out_channel_i) < NOISE_CHANNEL)
      |-> note_index_i <= NOTE_W'(MAX_NOTE))
    else $error("tone note index out of table range");

endmodule

bind psg_channel_run_length_note_tracker psgrlt_checker u_psgrlt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_channel_i    (out_o.out_channel),
  .new_run_i        (out_o.new_run),
  .note_index_i     (out_o.note_index),
  .run_attenuation_i(out_o.run_attenuation),
  .run_length_i     (out_o.run_length)
);
